@@ hdl/egbc_pkg.sv @@
package egbc_pkg;

    // default capture timer width
    localparam int CaptureWidthDef = 16;

    // echo width per cm
    localparam int EchoDiv = 58;

    // distance output saturation
    localparam logic [10:0] DIST_MAX = 11'h7FF;

    // decoupling queue depth between front and back
    localparam int QueueDepth = 4;

    // event kinds on the input beat
    localparam logic [1:0] MODE_ECHO = 2'd0;
    localparam logic [1:0] MODE_HOLD = 2'd1;
    localparam logic [1:0] MODE_STEP = 2'd2;

    // classified work passed from front to back
    localparam logic [1:0] K_NOP  = 2'd0;
    localparam logic [1:0] K_MEAS = 2'd1;
    localparam logic [1:0] K_HOLD = 2'd2;
    localparam logic [1:0] K_STEP = 2'd3;

    // motion state codes
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_OPEN  = 2'd1;
    localparam logic [1:0] ST_CLOSE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_NEAR   = 2'd0;
    localparam logic [1:0] CFG_HOLD   = 2'd1;
    localparam logic [1:0] CFG_TRAVEL = 2'd2;

    // configuration reset values
    localparam logic [10:0] NEAR_RST   = 11'd20;
    localparam logic [15:0] HOLD_RST   = 16'd1000;
    localparam logic [11:0] TRAVEL_RST = 12'd1365;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] capture_value;
    } t_in;

    typedef struct packed {
        logic [10:0] distance_cm;
        logic        distance_valid;
        logic [2:0]  drive_phase;
        logic        phase_valid;
        logic [1:0]  gate_state;
        logic        gate_open;
        logic        car_arrived;
    } t_out;

    typedef struct packed {
        logic [10:0] near_distance_cm;
        logic [15:0] hold_ticks;
        logic [11:0] travel_steps;
    } t_cfg;

endpackage

@@ hdl/egbc_queue.sv @@
module egbc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = egbc_pkg::QueueDepth
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic                       o_valid,
    output logic [WIDTH-1:0]           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    n_wr_ptr;
    logic [PW-1:0]    n_rd_ptr;
    logic [CW-1:0]    n_count;

    // pointer wrap at depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
endmodule

@@ hdl/egbc_front.sv @@
module egbc_front #(
    parameter int CAPTURE_WIDTH = egbc_pkg::CaptureWidthDef,
    parameter int QCW           = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  egbc_pkg::t_in                i_in_data,
    output logic                         o_in_stall,
    input  logic [QCW-1:0]               i_q_count,
    output logic                         o_push,
    output logic [1:0]                   o_kind,
    output logic [CAPTURE_WIDTH-6:0]     o_dist
);
    localparam int CW = CAPTURE_WIDTH;
    localparam int DW = CAPTURE_WIDTH - 5;
    localparam logic [CW-1:0] CAP_MAX = {CW{1'b1}};
    // floor(2^CW / 58); estimate is low by at most one
    localparam logic [CW-1:0] RECIP = CW'((64'd1 << CW) / egbc_pkg::EchoDiv);
    localparam logic [CW-1:0] DIV_C = CW'(egbc_pkg::EchoDiv);

    logic              w_accept;
    logic [CW+15:0]    w_cap_ext;
    logic [CW-1:0]     w_cap;
    logic [CW-1:0]     w_width;
    logic [2*CW-1:0]   w_prod;
    logic [CW-1:0]     w_q0_x58;
    logic [CW-1:0]     w_rem;
    logic [QCW+1:0]    w_inflight;

    logic              r_edge_pending;
    logic [CW-1:0]     r_first_time;
    logic              r_s1_valid;
    logic [1:0]        r_s1_kind;
    logic [CW-1:0]     r_s1_width;
    logic              r_s2_valid;
    logic [1:0]        r_s2_kind;
    logic [CW-1:0]     r_s2_width;
    logic [DW-1:0]     r_s2_q0;
    logic [1:0]        n_s1_kind;

    // credit check: queue entries plus beats still in the pipe
    assign w_inflight = (QCW+2)'(i_q_count) + (QCW+2)'(r_s1_valid) + (QCW+2)'(r_s2_valid);
    assign o_in_stall = (w_inflight >= (QCW+2)'(egbc_pkg::QueueDepth));
    assign w_accept   = i_in_valid && !o_in_stall;

    // capture value brought to the timer width
    assign w_cap_ext = {{CW{1'b0}}, i_in_data.capture_value};
    assign w_cap     = w_cap_ext[CW-1:0];

    // echo width with wrap
    assign w_width = (w_cap > r_first_time) ? (w_cap - r_first_time)
                                            : ((CAP_MAX - r_first_time) + w_cap);

    // classify the beat
    always_comb begin
        case (i_in_data.mode)
            egbc_pkg::MODE_ECHO: n_s1_kind = r_edge_pending ? egbc_pkg::K_MEAS
                                                            : egbc_pkg::K_NOP;
            egbc_pkg::MODE_HOLD: n_s1_kind = egbc_pkg::K_HOLD;
            egbc_pkg::MODE_STEP: n_s1_kind = egbc_pkg::K_STEP;
            default:             n_s1_kind = egbc_pkg::K_NOP;
        endcase
    end

    // edge pairing state and stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_pending <= 1'b0;
            r_s1_valid     <= 1'b0;
            r_s2_valid     <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            r_s2_valid <= r_s1_valid;
            if (w_accept && i_in_data.mode == egbc_pkg::MODE_ECHO) begin
                r_edge_pending <= !r_edge_pending;
            end
        end
    end

    // stage 1: width; stage 2: reciprocal product
    assign w_prod = (2*CW)'(r_s1_width) * (2*CW)'(RECIP);

    always_ff @(posedge i_clk) begin
        if (w_accept && i_in_data.mode == egbc_pkg::MODE_ECHO && !r_edge_pending) begin
            r_first_time <= w_cap;
        end
        r_s1_kind  <= n_s1_kind;
        r_s1_width <= w_width;
        r_s2_kind  <= r_s1_kind;
        r_s2_width <= r_s1_width;
        r_s2_q0    <= w_prod[CW+DW-1:CW];
    end

    // stage 3: remainder correction, push into queue
    assign w_q0_x58 = CW'(CW'(r_s2_q0) * DIV_C);
    assign w_rem    = r_s2_width - w_q0_x58;
    assign o_dist   = r_s2_q0 + DW'(w_rem >= DIV_C);
    assign o_kind   = r_s2_kind;
    assign o_push   = r_s2_valid;
endmodule

@@ hdl/egbc_back.sv @@
module egbc_back #(
    parameter int CAPTURE_WIDTH = egbc_pkg::CaptureWidthDef
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  egbc_pkg::t_cfg           i_cfg,
    input  logic                     i_q_valid,
    input  logic [1:0]               i_kind,
    input  logic [CAPTURE_WIDTH-6:0] i_dist,
    output logic                     o_pop,
    output logic                     o_out_valid,
    output egbc_pkg::t_out           o_out_data,
    input  logic                     i_out_stall
);
    localparam int DW   = CAPTURE_WIDTH - 5;
    localparam int CMPW = (DW > 11) ? DW : 11;

    logic [CMPW-1:0] w_dist;
    logic [CMPW-1:0] w_near;
    logic [15:0]     w_hold_inc;
    logic [2:0]      w_step_lo;

    logic            r_out_valid;
    egbc_pkg::t_out  r_out_data;
    egbc_pkg::t_out  n_out_data;
    logic [1:0]      r_state;
    logic [1:0]      n_state;
    logic            r_latched;
    logic            n_latched;
    logic            r_up;
    logic            n_up;
    logic [15:0]     r_hold_count;
    logic [15:0]     n_hold_count;
    logic [11:0]     r_step_index;
    logic [11:0]     n_step_index;
    logic            r_hold_on;
    logic            n_hold_on;
    logic            r_step_on;
    logic            n_step_on;

    // take the next queue entry whenever the output slot frees
    assign o_pop = i_q_valid && (!r_out_valid || !i_out_stall);

    assign w_dist     = CMPW'(i_dist);
    assign w_near     = CMPW'(i_cfg.near_distance_cm);
    assign w_hold_inc = r_hold_count + 16'd1;
    assign w_step_lo  = r_step_index[2:0];

    // motion control
    always_comb begin
        n_state      = r_state;
        n_latched    = r_latched;
        n_up         = r_up;
        n_hold_count = r_hold_count;
        n_step_index = r_step_index;
        n_hold_on    = r_hold_on;
        n_step_on    = r_step_on;
        n_out_data   = '0;
        case (i_kind)
            egbc_pkg::K_MEAS: begin
                n_out_data.distance_valid = 1'b1;
                n_out_data.distance_cm    = (w_dist > CMPW'(egbc_pkg::DIST_MAX))
                                            ? egbc_pkg::DIST_MAX : w_dist[10:0];
                if (w_dist < w_near && !r_latched) begin
                    n_hold_count            = '0;
                    n_state                 = egbc_pkg::ST_OPEN;
                    n_out_data.car_arrived  = 1'b1;
                    n_latched               = 1'b1;
                    n_hold_on               = 1'b1;
                    n_step_on               = 1'b1;
                end else if (w_dist > w_near && r_up && r_state != egbc_pkg::ST_CLOSE) begin
                    n_hold_count = '0;
                    n_state      = egbc_pkg::ST_CLOSE;
                    n_hold_on    = 1'b1;
                    n_step_on    = 1'b1;
                end
            end
            egbc_pkg::K_HOLD: begin
                if (r_hold_on) begin
                    if (r_state == egbc_pkg::ST_OPEN) begin
                        n_hold_count = w_hold_inc;
                        if (w_hold_inc >= i_cfg.hold_ticks) begin
                            n_up         = 1'b1;
                            n_latched    = 1'b1;
                            n_state      = egbc_pkg::ST_IDLE;
                            n_hold_count = '0;
                            n_hold_on    = 1'b0;
                        end
                    end else if (r_state == egbc_pkg::ST_CLOSE) begin
                        n_hold_count = w_hold_inc;
                        if (w_hold_inc >= i_cfg.hold_ticks) begin
                            n_up      = 1'b0;
                            n_latched = 1'b0;
                            n_state   = egbc_pkg::ST_IDLE;
                            n_hold_on = 1'b0;
                        end
                    end else begin
                        n_hold_count = '0;
                    end
                end
            end
            egbc_pkg::K_STEP: begin
                if (r_step_on) begin
                    if (r_state inside {egbc_pkg::ST_OPEN, egbc_pkg::ST_CLOSE}) begin
                        if (r_step_index < i_cfg.travel_steps) begin
                            n_out_data.drive_phase = (r_state == egbc_pkg::ST_OPEN)
                                                     ? w_step_lo : (3'd7 - w_step_lo);
                            n_out_data.phase_valid = 1'b1;
                            n_step_index           = r_step_index + 12'd1;
                        end else begin
                            n_step_index = '0;
                            n_step_on    = 1'b0;
                        end
                    end else begin
                        n_step_index = '0;
                    end
                end
            end
            default: begin
            end
        endcase
        n_out_data.gate_state = n_state;
        n_out_data.gate_open  = n_up;
    end

    // state and output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_state      <= egbc_pkg::ST_IDLE;
            r_latched    <= 1'b0;
            r_up         <= 1'b0;
            r_hold_count <= '0;
            r_step_index <= '0;
            r_hold_on    <= 1'b0;
            r_step_on    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_out_valid  <= 1'b1;
                r_state      <= n_state;
                r_latched    <= n_latched;
                r_up         <= n_up;
                r_hold_count <= n_hold_count;
                r_step_index <= n_step_index;
                r_hold_on    <= n_hold_on;
                r_step_on    <= n_step_on;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
endmodule

@@ hdl/echo_gated_barrier_controller.sv @@
// Echo-gated barrier controller.
// Input channel (i_in_valid / o_in_stall, payload i_in_data): one beat per event,
// either an echo capture edge with its timer value, a hold-timer tick or a
// step-timer tick. Edges pair up: the second of a pair yields a distance.
// Output channel (o_out_valid / i_out_stall, payload o_out_data): exactly one
// result beat per input beat, in order, carrying distance, stepper phase,
// gate state and the arrival pulse.
// Config channel (i_cfg_valid / o_cfg_ready): index 0 threshold, 1 hold ticks,
// 2 travel steps. Always ready; write only while the block is idle.
// Path from input beat to result beat: width, reciprocal
// multiply, correction into a 4-entry queue, then the motion unit.
// Throughput: one beat per cycle while the receiver does not stall.
// Reset clears the edge pairing, motion state, counters and timers, and loads
// the register defaults (20 cm, 1000 ticks, 1365 steps).
// When the receiver stalls, the output slot holds, the queue fills, and the
// input stalls once queue plus in-flight beats reach the queue depth.
module echo_gated_barrier_controller #(
    parameter int CAPTURE_WIDTH = egbc_pkg::CaptureWidthDef
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  egbc_pkg::t_in  i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output egbc_pkg::t_out o_out_data,
    input  logic           i_out_stall,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [15:0]    i_cfg_data
);
    localparam int DW  = CAPTURE_WIDTH - 5;
    localparam int QCW = $clog2(egbc_pkg::QueueDepth + 1);

    egbc_pkg::t_cfg  r_cfg;
    logic            w_push;
    logic [1:0]      w_push_kind;
    logic [DW-1:0]   w_push_dist;
    logic            w_pop;
    logic            w_q_valid;
    logic [DW+1:0]   w_q_data;
    logic [QCW-1:0]  w_q_count;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_distance_cm <= egbc_pkg::NEAR_RST;
            r_cfg.hold_ticks       <= egbc_pkg::HOLD_RST;
            r_cfg.travel_steps     <= egbc_pkg::TRAVEL_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                egbc_pkg::CFG_NEAR:   r_cfg.near_distance_cm <= i_cfg_data[10:0];
                egbc_pkg::CFG_HOLD:   r_cfg.hold_ticks       <= i_cfg_data;
                egbc_pkg::CFG_TRAVEL: r_cfg.travel_steps     <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    egbc_front #(
        .CAPTURE_WIDTH (CAPTURE_WIDTH),
        .QCW           (QCW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_count  (w_q_count),
        .o_push     (w_push),
        .o_kind     (w_push_kind),
        .o_dist     (w_push_dist)
    );

    egbc_queue #(
        .WIDTH (DW + 2),
        .DEPTH (egbc_pkg::QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_push_kind, w_push_dist}),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .o_count (w_q_count)
    );

    egbc_back #(
        .CAPTURE_WIDTH (CAPTURE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_kind      (w_q_data[DW+1:DW]),
        .i_dist      (w_q_data[DW-1:0]),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // credit scheme must never overrun the queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |-> w_q_count < QCW'(egbc_pkg::QueueDepth))
        else $error("decoupling queue overrun");

    // an arrival pulse only comes with a measurement that starts opening
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.car_arrived |->
            o_out_data.distance_valid && o_out_data.gate_state == egbc_pkg::ST_OPEN)
        else $error("arrival without opening measurement");

    // a result never carries both a measurement and a phase
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.distance_valid && o_out_data.phase_valid))
        else $error("distance and phase in one result");

    // a phase is only emitted while a motion is under way
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.phase_valid |->
            o_out_data.gate_state == egbc_pkg::ST_OPEN ||
            o_out_data.gate_state == egbc_pkg::ST_CLOSE)
        else $error("phase emitted while idle");
endmodule
